// ----- hw/rtl/crc32fc_pkg.sv -----
package crc32fc_pkg;

  localparam int unsigned CRC_W = 32;
  localparam int unsigned LEN_W = 10;
  localparam int unsigned POS_W = LEN_W + 1;
  localparam int unsigned CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_CRC_POLYNOMIAL = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COVERED_LENGTH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SYNC_VALUE     = 2'd2;

  localparam logic [CRC_W-1:0] RESET_CRC_POLYNOMIAL = 32'hEDB8_8320;
  localparam logic [LEN_W-1:0] RESET_COVERED_LENGTH = 10'd108;
  localparam logic [7:0]       RESET_SYNC_VALUE     = 8'hAA;

  // Number of checksum bytes that trail the covered bytes
  localparam logic [POS_W-1:0] CHECKSUM_BYTES = 11'd4;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_CRC_ERR  = 2'd1;
  localparam logic [1:0] STATUS_SYNC_ERR = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_word_t;

  typedef struct packed {
    logic             frame_ok;
    logic [1:0]       status;
    logic [CRC_W-1:0] computed_crc;
    logic [CRC_W-1:0] received_crc;
  } out_word_t;

  typedef struct packed {
    logic [CRC_W-1:0] crc_polynomial;
    logic [LEN_W-1:0] covered_length;
    logic [7:0]       sync_value;
  } cfg_t;

  // Reflected CRC update over one byte, LSB first
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [7:0]       b,
                                                input logic [CRC_W-1:0] poly);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-8){1'b0}}, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ poly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/crc32fc_cfg.sv -----
module crc32fc_cfg
  import crc32fc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CRC_W-1:0]       cfg_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.crc_polynomial <= RESET_CRC_POLYNOMIAL;
      cfg.covered_length <= RESET_COVERED_LENGTH;
      cfg.sync_value     <= RESET_SYNC_VALUE;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_CRC_POLYNOMIAL: cfg.crc_polynomial <= cfg_data;
        REG_COVERED_LENGTH: cfg.covered_length <= cfg_data[LEN_W-1:0];
        REG_SYNC_VALUE:     cfg.sync_value     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/crc32fc_frame.sv -----
module crc32fc_frame
  import crc32fc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      take,
  input  in_word_t  word,
  output logic      res_valid,
  output out_word_t res
);

  logic [CRC_W-1:0] crc_acc, crc_acc_next;
  logic [POS_W-1:0] byte_pos, byte_pos_next;
  logic [CRC_W-1:0] chk_shift, chk_shift_next;
  logic             sync_ok, sync_ok_next;

  logic [CRC_W-1:0] crc_cur;
  logic [POS_W-1:0] pos_cur;
  logic [CRC_W-1:0] shift_cur;
  logic             sync_cur;
  logic [POS_W-1:0] len_ext;
  logic [POS_W-1:0] frame_end;

  assign len_ext   = {1'b0, cfg.covered_length};
  assign frame_end = len_ext + CHECKSUM_BYTES;

  always_comb begin
    // frame start clears everything before the byte counts as byte 0
    crc_cur   = word.frame_start ? '0 : crc_acc;
    pos_cur   = word.frame_start ? '0 : byte_pos;
    shift_cur = word.frame_start ? '0 : chk_shift;
    sync_cur  = word.frame_start ? 1'b0 : sync_ok;

    crc_acc_next   = crc_cur;
    byte_pos_next  = pos_cur;
    chk_shift_next = shift_cur;
    sync_ok_next   = sync_cur;
    res_valid      = 1'b0;

    if (pos_cur < frame_end) begin
      if (pos_cur == '0) begin
        sync_ok_next = (word.data_byte == cfg.sync_value);
      end
      byte_pos_next = pos_cur + 1'b1;
      if (pos_cur < len_ext) begin
        crc_acc_next = crc_byte(crc_cur, word.data_byte, cfg.crc_polynomial);
      end else begin
        chk_shift_next = {word.data_byte, shift_cur[CRC_W-1:8]};
        res_valid      = (byte_pos_next == frame_end);
      end
    end

    res.computed_crc = crc_acc_next;
    res.received_crc = chk_shift_next;
    // CRC mismatch wins over a bad sync byte
    if (chk_shift_next != crc_acc_next) begin
      res.status = STATUS_CRC_ERR;
    end else if (!sync_ok_next) begin
      res.status = STATUS_SYNC_ERR;
    end else begin
      res.status = STATUS_OK;
    end
    res.frame_ok = (res.status == STATUS_OK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_acc   <= '0;
      byte_pos  <= '0;
      chk_shift <= '0;
      sync_ok   <= 1'b0;
    end else if (take) begin
      crc_acc   <= crc_acc_next;
      byte_pos  <= byte_pos_next;
      chk_shift <= chk_shift_next;
      sync_ok   <= sync_ok_next;
    end
  end

endmodule

// ----- hw/rtl/crc32fc_out_buf.sv -----
module crc32fc_out_buf
  import crc32fc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  out_word_t load_word,
  output logic      full_stalled,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  // upstream may only advance when the held word is gone or leaving now
  assign full_stalled = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_word;
    end
  end

endmodule

// ----- hw/rtl/crc32_frame_checker.sv -----
// Checks received frames one byte per word: the first covered_length bytes run
// through a reflected, zero-init CRC-32 with the configured polynomial, the next
// four bytes are taken as the little-endian checksum, and one result word is
// registered in the output buffer on the last checksum byte. A byte with
// frame_start set restarts the frame; bytes after a finished frame are dropped
// until then. Throughput is one byte per cycle while not stalled, with the
// unrolled eight-bit CRC update. Input is stalled only while a result word is
// held and the output side is stalling. Write configuration only while idle.
module crc32_frame_checker
  import crc32fc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_word_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_word_t              out_data,
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CRC_W-1:0]       cfg_data
);

  cfg_t      cfg;
  logic      take;
  logic      res_valid;
  out_word_t res;
  logic      full_stalled;

  assign in_stall = full_stalled;
  assign take     = in_valid && !full_stalled;

  crc32fc_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg)
  );

  crc32fc_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .take      (take),
    .word      (in_data),
    .res_valid (res_valid),
    .res       (res)
  );

  crc32fc_out_buf u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (take && res_valid),
    .load_word    (res),
    .full_stalled (full_stalled),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule
